// ===== design/rope_pkg.sv =====
// Shared types and constants for the rotary position embedding unit.
package rope_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PASS   = 2'd0;
  localparam kind_t KIND_FIRST  = 2'd1;
  localparam kind_t KIND_SECOND = 2'd2;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_FEATURE_DIM = 2'd0;
  localparam reg_index_t REG_ROTARY_DIM  = 2'd1;
  localparam reg_index_t REG_PAIR_MODE   = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         slot;
    logic [7:0]         first_idx;
    logic [7:0]         pos;
    logic               last;
    logic signed [15:0] sample;
    logic signed [15:0] cos_val;
    logic signed [15:0] sin_val;
  } item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         index;
    logic               done;
  } res_t;

endpackage

// ===== design/rotary_position_embedding_unit.sv =====
// Top level of the rotary position embedding unit: front end, queue and back end.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   sample, cos_val, sin_val
//   output    out        out_valid / out_stall out_value, out_index, row_done
//   config    in         cfg_write             cfg_index, cfg_data
//
// At most one element is taken per cycle, none while the queue is full; a pass-through
// element gives one result, the first element of a pair none and the second two, one
// after the other; a new result is loaded as the last buffered one is taken. A result
// reaches the output through the queue, the pair store read stage, the product stage
// and the result register. Reset clears the configuration to its defaults, the row
// position and all valid flags; the pair store is not cleared.
// A stall on the output holds the back end, and the queue absorbs up to four elements.
module rotary_position_embedding_unit #(
  parameter int MAX_DIM = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  rope_pkg::reg_index_t cfg_index,
  input  logic [8:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   sample,
  input  logic signed [15:0]   cos_val,
  input  logic signed [15:0]   sin_val,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_value,
  output logic [7:0]           out_index,
  output logic                 row_done
);

  logic            push;
  logic            queue_full;
  logic            pop;
  logic            head_valid;
  rope_pkg::item_t push_item;
  rope_pkg::item_t head;

  assign in_stall = queue_full;

  rope_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .queue_full (queue_full),
    .sample     (sample),
    .cos_val    (cos_val),
    .sin_val    (sin_val),
    .push       (push),
    .item       (push_item)
  );

  rope_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  rope_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_index  (out_index),
    .row_done   (row_done)
  );

endmodule

// ===== design/rope_front.sv =====
// Front end: configuration registers, row position and classification of each element.
module rope_front #(
  parameter int MAX_DIM = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  rope_pkg::reg_index_t  cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic                  in_valid,
  input  logic                  queue_full,
  input  logic signed [15:0]    sample,
  input  logic signed [15:0]    cos_val,
  input  logic signed [15:0]    sin_val,
  output logic                  push,
  output rope_pkg::item_t       item
);

  localparam int CAP = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam logic [8:0] CAP9 = 9'(CAP);

  logic [8:0] feature_dim;
  logic [8:0] rotary_dim;
  logic       pair_mode;
  logic [7:0] row_position;

  logic [8:0] d;
  logic [8:0] e;
  logic [8:0] half;
  logic [8:0] pos9;
  logic [8:0] diff;
  logic [8:0] pos_next;

  assign push = in_valid && !queue_full;

  always_comb begin
    d = feature_dim;
    if (d == 9'd0) begin
      d = 9'd1;
    end
    if (d > CAP9) begin
      d = CAP9;
    end
    e = (rotary_dim < d) ? rotary_dim : d;
    e[0] = 1'b0;
    half = e >> 1;
    pos9 = {1'b0, row_position};
    if (pos9 >= d) begin
      pos9 = 9'd0;
    end
    diff = pos9 - half;
    pos_next = pos9 + 9'd1;
    if (pos_next >= d) begin
      pos_next = 9'd0;
    end

    item.pos       = pos9[7:0];
    item.last      = (pos9 == (d - 9'd1));
    item.sample    = sample;
    item.cos_val   = cos_val;
    item.sin_val   = sin_val;
    item.slot      = 8'd0;
    item.first_idx = 8'd0;
    if (pos9 >= e) begin
      item.kind = rope_pkg::KIND_PASS;
    end else if (pair_mode) begin
      item.kind      = pos9[0] ? rope_pkg::KIND_SECOND : rope_pkg::KIND_FIRST;
      item.slot      = pos9[8:1];
      item.first_idx = pos9[7:0] - 8'd1;
    end else if (pos9 >= half) begin
      item.kind      = rope_pkg::KIND_SECOND;
      item.slot      = diff[7:0];
      item.first_idx = diff[7:0];
    end else begin
      item.kind = rope_pkg::KIND_FIRST;
      item.slot = pos9[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_dim  <= 9'd128;
      rotary_dim   <= 9'd64;
      pair_mode    <= 1'b0;
      row_position <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rope_pkg::REG_FEATURE_DIM: begin
          feature_dim  <= cfg_data;
          row_position <= 8'd0;
        end
        rope_pkg::REG_ROTARY_DIM: begin
          rotary_dim   <= cfg_data;
          row_position <= 8'd0;
        end
        rope_pkg::REG_PAIR_MODE: begin
          pair_mode    <= cfg_data[0];
          row_position <= 8'd0;
        end
        default: begin
        end
      endcase
    end else if (push) begin
      row_position <= pos_next[7:0];
    end
  end

endmodule

// ===== design/rope_queue.sv =====
// Short queue of classified elements between the front and back ends.
module rope_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rope_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output rope_pkg::item_t head
);

  rope_pkg::item_t                entries [rope_pkg::QUEUE_DEPTH];
  logic [rope_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [rope_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [rope_pkg::QUEUE_AW:0]    count;

  assign full       = (count == (rope_pkg::QUEUE_AW + 1)'(rope_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/rope_back.sv =====
// Back end: pair store, rotation products, rounding, saturation and result buffer.
module rope_back #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  rope_pkg::item_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_value,
  output logic [7:0]         out_index,
  output logic               row_done
);

  localparam int STORE_DEPTH = (MAX_DIM / 2 > 0) ? MAX_DIM / 2 : 1;
  localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic signed [15:0] pair_store [STORE_DEPTH];
  logic [SLOT_W-1:0]  head_slot;

  logic               s1_valid;
  rope_pkg::kind_t    s1_kind;
  logic [7:0]         s1_first_idx;
  logic [7:0]         s1_pos;
  logic               s1_last;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_c;
  logic signed [15:0] s1_s;
  logic signed [15:0] s1_x0;

  logic               s2_valid;
  rope_pkg::kind_t    s2_kind;
  logic [7:0]         s2_first_idx;
  logic [7:0]         s2_pos;
  logic               s2_last;
  logic signed [15:0] s2_x;
  logic signed [31:0] p_x0c;
  logic signed [31:0] p_xs;
  logic signed [31:0] p_x0s;
  logic signed [31:0] p_xc;

  rope_pkg::res_t     res0;
  rope_pkg::res_t     res1;
  logic [1:0]         cnt;

  logic               take;
  logic               can_load;
  logic               load;
  logic               adv;
  logic signed [33:0] sum_a;
  logic signed [33:0] sum_b;
  logic signed [15:0] rot_a;
  logic signed [15:0] rot_b;

  function automatic logic signed [15:0] round_sat(input logic signed [33:0] sum);
    logic signed [33:0] q;
    q = (sum + 34'sd8192) >>> 14;
    if (q > 34'sd32767) begin
      return 16'sh7fff;
    end else if (q < -34'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  assign head_slot = SLOT_W'(head.slot);
  assign take      = (cnt != 2'd0) && !out_stall;
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && take);
  assign load      = s2_valid && can_load;
  assign adv       = !s2_valid || can_load;
  assign pop       = adv && head_valid;

  assign sum_a = 34'(p_x0c) - 34'(p_xs);
  assign sum_b = 34'(p_x0s) + 34'(p_xc);
  assign rot_a = round_sat(sum_a);
  assign rot_b = round_sat(sum_b);

  assign out_valid = (cnt != 2'd0);
  assign out_value = res0.value;
  assign out_index = res0.index;
  assign row_done  = res0.done;

  always_ff @(posedge clk) begin
    if (pop && (head.kind == rope_pkg::KIND_FIRST)) begin
      pair_store[head_slot] <= head.sample;
    end
    if (adv) begin
      s1_x0 <= pair_store[head_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind      <= head.kind;
      s1_first_idx <= head.first_idx;
      s1_pos       <= head.pos;
      s1_last      <= head.last;
      s1_x         <= head.sample;
      s1_c         <= head.cos_val;
      s1_s         <= head.sin_val;
      s2_kind      <= s1_kind;
      s2_first_idx <= s1_first_idx;
      s2_pos       <= s1_pos;
      s2_last      <= s1_last;
      s2_x         <= s1_x;
      p_x0c        <= s1_x0 * s1_c;
      p_xs         <= s1_x * s1_s;
      p_x0s        <= s1_x0 * s1_s;
      p_xc         <= s1_x * s1_c;
    end
    if (load) begin
      if (s2_kind == rope_pkg::KIND_PASS) begin
        res0 <= '{value: s2_x, index: s2_pos, done: s2_last};
      end else begin
        res0 <= '{value: rot_a, index: s2_first_idx, done: 1'b0};
        res1 <= '{value: rot_b, index: s2_pos, done: s2_last};
      end
    end else if (take) begin
      res0 <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      cnt      <= 2'd0;
    end else begin
      if (adv) begin
        s1_valid <= head_valid;
        s2_valid <= s1_valid && (s1_kind != rope_pkg::KIND_FIRST);
      end
      if (load) begin
        cnt <= (s2_kind == rope_pkg::KIND_PASS) ? 2'd1 : 2'd2;
      end else if (take) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ===== tb/rotary_position_embedding_unit_test.sv =====
// Self-checking testbench for the rotary position embedding unit with randomised stimulus and idling.
module rotary_position_embedding_unit_test;

  localparam rope_pkg::reg_index_t REG_UNUSED = 2'd3;
  localparam int STORE_SLOTS = 128;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct {
    logic signed [15:0] data;
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
  } elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  rope_pkg::reg_index_t cfg_index = rope_pkg::REG_FEATURE_DIM;
  logic [8:0] cfg_data = 9'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample = 16'sd0;
  logic signed [15:0] cos_val = 16'sd0;
  logic signed [15:0] sin_val = 16'sd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_value;
  logic [7:0] out_index;
  logic row_done;

  elem_t pending_elems[$];
  rope_pkg::res_t expected_outputs[$];
  rope_pkg::res_t head;
  int queued_total = 0;
  int taken_total = 0;
  int failures = 0;
  int gap_max = 9;
  int stall_max = 9;
  int gap_left = 0;
  int stall_left = 0;
  bit elem_taken = 1'b0;

  logic [8:0] feature_dim_reg = 9'd128;
  logic [8:0] rotary_dim_reg = 9'd64;
  logic pair_mode_reg = 1'b0;
  logic signed [15:0] pair_first[STORE_SLOTS];
  int unsigned row_pos = 0;

  rotary_position_embedding_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .cos_val(cos_val),
    .sin_val(sin_val),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_index(out_index),
    .row_done(row_done)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] scale_saturate(input longint sum);
    longint q;
    q = (sum + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  task automatic rope_predict(input logic signed [15:0] x, input logic signed [15:0] c,
                              input logic signed [15:0] s);
    int unsigned d, e, half, pos, slot, first_idx;
    bit last, second;
    longint x0;
    rope_pkg::res_t r;
    d = feature_dim_reg;
    if (d < 1) d = 1;
    if (d > 256) d = 256;
    e = (rotary_dim_reg < d) ? rotary_dim_reg : d;
    e = e & ~32'd1;
    half = e / 2;
    pos = row_pos;
    if (pos >= d) pos = 0;
    last = (pos == d - 1);
    if (pos >= e) begin
      r.value = x;
      r.index = pos[7:0];
      r.done = last;
      expected_outputs.push_back(r);
    end else begin
      if (pair_mode_reg) begin
        second = pos[0];
        slot = pos >> 1;
        first_idx = pos - 1;
      end else begin
        second = (pos >= half);
        slot = second ? pos - half : pos;
        first_idx = pos - half;
      end
      slot = slot % STORE_SLOTS;
      if (!second) begin
        pair_first[slot] = x;
      end else begin
        x0 = pair_first[slot];
        r.value = scale_saturate(x0 * longint'(c) - longint'(x) * longint'(s));
        r.index = first_idx[7:0];
        r.done = 1'b0;
        expected_outputs.push_back(r);
        r.value = scale_saturate(x0 * longint'(s) + longint'(x) * longint'(c));
        r.index = pos[7:0];
        r.done = last;
        expected_outputs.push_back(r);
      end
    end
    pos++;
    if (pos >= d) pos = 0;
    row_pos = pos & 32'hFF;
  endtask

  // Input and output transfers are both taken at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rope_predict(sample, cos_val, sin_val);
        taken_total++;
        elem_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected result: out_value %0d out_index %0d row_done %0d",
                 out_value, out_index, row_done);
          failures++;
        end else begin
          head = expected_outputs.pop_front();
          if (out_value !== head.value) begin
            $error("out_value: expected %0d, got %0d", head.value, out_value);
            failures++;
          end
          if (out_index !== head.index) begin
            $error("out_index: expected %0d, got %0d", head.index, out_index);
            failures++;
          end
          if (row_done !== head.done) begin
            $error("row_done: expected %0d, got %0d", head.done, row_done);
            failures++;
          end
        end
        stall_left = $urandom_range(stall_max);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || elem_taken) begin
      elem_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        sample <= pending_elems[0].data;
        cos_val <= pending_elems[0].cosine;
        sin_val <= pending_elems[0].sine;
        void'(pending_elems.pop_front());
        in_valid <= 1'b1;
        gap_left = $urandom_range(gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_elem(input int x, input int c, input int s);
    elem_t el;
    el.data = 16'(x);
    el.cosine = 16'(c);
    el.sine = 16'(s);
    pending_elems.push_back(el);
    queued_total++;
  endtask

  task automatic queue_random_elem();
    int x, c, s;
    case ($urandom_range(9))
      0: x = 32767;
      1: x = -32768;
      default: x = $urandom;
    endcase
    case ($urandom_range(9))
      0: begin
        c = $urandom;
        s = $urandom;
      end
      1: begin
        c = $urandom_range(1) ? 16384 : -16384;
        s = $urandom_range(1) ? 16384 : -16384;
      end
      default: begin
        c = int'($urandom_range(32768)) - 16384;
        s = int'($urandom_range(32768)) - 16384;
      end
    endcase
    queue_elem(x, c, s);
  endtask

  // Waits until every transfer has gone in and every result has come out.
  task automatic drain();
    while (taken_total != queued_total || expected_outputs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input rope_pkg::reg_index_t idx, input logic [8:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      rope_pkg::REG_FEATURE_DIM: begin
        feature_dim_reg = value;
        row_pos = 0;
      end
      rope_pkg::REG_ROTARY_DIM: begin
        rotary_dim_reg = value;
        row_pos = 0;
      end
      rope_pkg::REG_PAIR_MODE: begin
        pair_mode_reg = value[0];
        row_pos = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input int fdim, input int rdim, input bit mode);
    write_reg(rope_pkg::REG_FEATURE_DIM, 9'(fdim));
    write_reg(rope_pkg::REG_ROTARY_DIM, 9'(rdim));
    write_reg(rope_pkg::REG_PAIR_MODE, {9'($urandom) & 9'h1FE} | 9'(mode));
  endtask

  initial begin
    int random_items, phase, fdim, rdim, deff, count, split;
    bit mode;
    random_items = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: one full row, with the sender holding off part way through.
    for (int i = 0; i < 128; i++) begin
      if (i == 40) drain();
      queue_random_elem();
    end
    random_items += 128;
    drain();

    gap_max = 2;
    stall_max = 2;
    configure(6, 4, 1'b1);
    queue_elem(32767, 0, 0);
    queue_elem(32767, 16384, 16384);
    queue_elem(-32768, 0, 0);
    queue_elem(-32768, -32768, -32768);
    queue_elem(32767, 16384, -16384);
    queue_elem(-32768, -16384, 16384);
    drain();
    configure(5, 5, 1'b0);
    queue_elem(12345, 0, 0);
    queue_elem(-32768, 0, 0);
    queue_elem(-1, 16384, 0);
    queue_elem(32767, 16385, 32767);
    queue_elem(-32768, 0, 0);
    drain();
    configure(0, 0, 1'b0);
    queue_elem(-32768, 0, 0);
    queue_elem(32767, 0, 0);
    drain();
    configure(2, 511, 1'b1);
    queue_elem(-32768, -16384, -16384);
    queue_elem(-32768, -16384, 16384);
    drain();
    write_reg(REG_UNUSED, 9'h1FF);
    queue_elem(1, 0, 0);
    queue_elem(-2, 16384, 16384);
    drain();

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        fdim = 511;
        rdim = 256;
        mode = 1'b0;
      end else if (phase == 1) begin
        fdim = 256;
        rdim = 256;
        mode = 1'b1;
      end else begin
        case ($urandom_range(29))
          0: fdim = 0;
          1: fdim = 256;
          2: fdim = $urandom_range(511, 257);
          3, 4: fdim = $urandom_range(255, 17);
          default: fdim = $urandom_range(16, 1);
        endcase
        mode = $urandom_range(1);
      end
      deff = (fdim < 1) ? 1 : (fdim > 256) ? 256 : fdim;
      if (phase > 1) begin
        case ($urandom_range(5))
          0: rdim = 0;
          1: rdim = deff;
          2: rdim = $urandom_range(511, deff);
          default: rdim = $urandom_range(deff);
        endcase
      end
      case ($urandom_range(2))
        0: gap_max = 0;
        1: gap_max = 9;
        default: gap_max = $urandom_range(9);
      endcase
      case ($urandom_range(2))
        0: stall_max = 0;
        1: stall_max = 9;
        default: stall_max = $urandom_range(9);
      endcase
      configure(fdim, rdim, mode);
      count = (deff > 16) ? deff : deff * $urandom_range(4, 1);
      if (deff > 1 && $urandom_range(4) == 0) count += $urandom_range(deff - 1, 1);
      split = ($urandom_range(5) == 0) ? $urandom_range(count) : -1;
      for (int i = 0; i < count; i++) begin
        if (i == split) drain();
        queue_random_elem();
      end
      random_items += count;
      drain();
      phase++;
    end

    drain();
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
